// ----- hw/rtl/fcp_pkg.sv -----
// Shared types, constants and the digit decoder for the framed coordinate packet parser.
// Used by fcp_frame, fcp_coord and framed_coordinate_packet_parser_top; depends on nothing.
package fcp_pkg;

    // Default payload length between the opening and the closing marks.
    localparam int PAYLOAD_LEN_DEF = 12;

    // Framing and character codes.
    localparam logic [7:0] MARK_BYTE  = 8'h40;  // '@'
    localparam logic [7:0] ASCII_ZERO = 8'h30;  // '0'
    localparam logic [7:0] KIND_RED   = 8'h52;  // 'R'
    localparam logic [7:0] KIND_GREEN = 8'h47;  // 'G'
    localparam logic [7:0] KIND_BLUE  = 8'h42;  // 'B'
    localparam logic [7:0] KIND_COLOR = 8'h43;  // 'C'

    // Fixed payload positions.
    localparam int POS_KIND  = 0;
    localparam int POS_X     = 1;
    localparam int POS_Y     = 4;
    localparam int POS_COLOR = 7;

    // Width of the color selection register.
    localparam int TCOLOR_W = 4;

    // Framing phases; the unused code is handled as idle.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ARMED   = 2'd2
    } phase_t;

    // Frame state as it stands after the current byte, plus per-byte status.
    typedef struct packed {
        logic [7:0]  kind;
        logic [7:0]  color;
        logic [15:0] x;
        logic [15:0] y;
        logic        committed;
        logic        error;
    } frame_info_t;

    // Three ASCII digits weighted 100/10/1, wrapping at 16 bits.
    function automatic logic [15:0] decode3(input logic [7:0] d0,
                                            input logic [7:0] d1,
                                            input logic [7:0] d2);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        a = {8'h00, d0} - {8'h00, ASCII_ZERO};
        b = {8'h00, d1} - {8'h00, ASCII_ZERO};
        c = {8'h00, d2} - {8'h00, ASCII_ZERO};
        return (a * 16'd100) + (b * 16'd10) + c;
    endfunction

endpackage

// ----- hw/rtl/fcp_frame.sv -----
// Framing state machine, payload store and field decode of the packet parser.
// Depends on fcp_pkg.
module fcp_frame #(
    parameter int PAYLOAD_LEN = fcp_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          rx_byte,
    output fcp_pkg::frame_info_t info
);
    import fcp_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_LEN + 1);
    localparam int IDX_W = $clog2(PAYLOAD_LEN);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         kind_reg, kind_next;
    logic [7:0]         color_reg, color_next;
    logic [15:0]        x_reg, x_next;
    logic [15:0]        y_reg, y_next;
    logic [7:0]         store [PAYLOAD_LEN];
    logic               store_we;
    logic               is_mark;
    logic               full;
    logic               committed;
    logic               error;

    assign is_mark = (rx_byte == MARK_BYTE);
    assign full    = (count_reg == CNT_W'(PAYLOAD_LEN));

    // Next phase, payload count and latched frame fields for the current byte.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        color_next = color_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        store_we   = 1'b0;
        committed  = 1'b0;
        error      = 1'b0;
        case (phase_reg)
            PH_PAYLOAD: begin
                if (full) begin
                    if (is_mark) begin
                        phase_next = PH_ARMED;
                    end else begin
                        // Overrun: drop the frame and report it.
                        phase_next = PH_IDLE;
                        count_next = '0;
                        error      = 1'b1;
                    end
                end else begin
                    store_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            PH_ARMED: begin
                if (is_mark) begin
                    kind_next  = store[POS_KIND];
                    color_next = store[POS_COLOR];
                    x_next     = decode3(store[POS_X], store[POS_X + 1], store[POS_X + 2]);
                    y_next     = decode3(store[POS_Y], store[POS_Y + 1], store[POS_Y + 2]);
                    phase_next = PH_IDLE;
                    count_next = '0;
                    committed  = 1'b1;
                end
            end
            default: begin
                if (is_mark) begin
                    phase_next = PH_PAYLOAD;
                    count_next = '0;
                end
            end
        endcase
    end

    // Control and latched field registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            kind_reg  <= '0;
            color_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            color_reg <= color_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    // Payload store, one byte written per payload transfer while the payload is not full.
    always_ff @(posedge aclk) begin
        if (step_en && store_we) begin
            store[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign info.kind      = kind_next;
    assign info.color     = color_next;
    assign info.x         = x_next;
    assign info.y         = y_next;
    assign info.committed = committed;
    assign info.error     = error;

endmodule

// ----- hw/rtl/fcp_coord.sv -----
// Coordinate selection registers and the result register of the packet parser.
// Depends on fcp_pkg.
module fcp_coord (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  fcp_pkg::frame_info_t          info,
    input  logic [fcp_pkg::TCOLOR_W-1:0]  target_color,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [15:0]                   blob_x,
    output logic [15:0]                   blob_y,
    output logic [15:0]                   target_x,
    output logic [15:0]                   target_y,
    output logic                          frame_committed,
    output logic                          frame_error
);
    import fcp_pkg::*;

    logic [31:0] blob_reg, blob_next;
    logic [31:0] target_reg, target_next;
    logic        valid_reg;
    logic [31:0] pair;
    logic        is_blob;
    logic        is_target;
    logic        color_ok;

    // Copy the latched pair according to the packet kind and the color filter.
    always_comb begin
        pair      = {info.y, info.x};
        is_blob   = (info.kind == KIND_RED) || (info.kind == KIND_GREEN) ||
                    (info.kind == KIND_BLUE);
        color_ok  = (target_color == '0) ||
                    (info.color == ({{(8 - TCOLOR_W){1'b0}}, target_color} + ASCII_ZERO));
        is_target = (info.kind == KIND_COLOR) && color_ok;
        blob_next   = is_blob   ? pair : blob_reg;
        target_next = is_target ? pair : target_reg;
    end

    // Coordinate state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blob_reg   <= '0;
            target_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            if (step_en) begin
                blob_reg   <= blob_next;
                target_reg <= target_next;
                valid_reg  <= 1'b1;
            end else if (m_tready) begin
                valid_reg  <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            blob_x          <= blob_next[15:0];
            blob_y          <= blob_next[31:16];
            target_x        <= target_next[15:0];
            target_y        <= target_next[31:16];
            frame_committed <= info.committed;
            frame_error     <= info.error;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// ----- hw/rtl/framed_coordinate_packet_parser_top.sv -----
// Top level of the framed coordinate packet parser: input register, handshake control,
// color selection register and assertions. Depends on fcp_pkg, fcp_frame and fcp_coord.
//
// Usage:
// The s_ channel takes one received serial byte per transfer in s_tdata. Frames have
// the form '@', PAYLOAD_LEN payload bytes, '@', '@'. Every input byte yields exactly
// one transfer on the m_ channel carrying the current blob and target coordinates,
// with m_tlast high when that byte committed a frame and m_tuser high when it overran
// the payload and aborted the frame.
// cfg_we writes cfg_wdata into the color selection register (0 accepts any color);
// write it only while no bytes are in flight.
// An accepted input transfer loads the byte into the input register, and the byte
// then moves through the framing and decode into the result register. Throughput
// is one byte per cycle while the receiver does not stall, since the framing and
// decode path between those two registers is combinational.
// When the receiver stalls, the result register holds and one more byte waits in
// the input register; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both registers, returns the framer to idle
// and clears the coordinates, the latched frame fields and the color selection.
module framed_coordinate_packet_parser_top #(
    parameter int PAYLOAD_LEN = fcp_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // [15:0] blob_x, [31:16] blob_y,
                                                     // [47:32] target_x, [63:48] target_y
    output logic                          m_tlast,   // frame_committed
    output logic                          m_tuser,   // [0] frame_error
    // Configuration
    input  logic                          cfg_we,
    input  logic [fcp_pkg::TCOLOR_W-1:0]  cfg_wdata  // target_color
);
    import fcp_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic [TCOLOR_W-1:0] tcolor_reg;
    logic                step_en;
    logic                in_xfer;
    frame_info_t         info;
    logic [15:0]         blob_x, blob_y, target_x, target_y;
    logic                frame_committed, frame_error;

    // Handshake: a byte moves on when the result register is free or draining.
    assign step_en  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Color selection register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcolor_reg <= '0;
        end else if (cfg_we) begin
            tcolor_reg <= cfg_wdata;
        end
    end

    fcp_frame #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .info    (info)
    );

    fcp_coord u_coord (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (step_en),
        .info            (info),
        .target_color    (tcolor_reg),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .blob_x          (blob_x),
        .blob_y          (blob_y),
        .target_x        (target_x),
        .target_y        (target_y),
        .frame_committed (frame_committed),
        .frame_error     (frame_error)
    );

    assign m_tdata = {target_y, target_x, blob_y, blob_x};
    assign m_tlast = frame_committed;
    assign m_tuser = frame_error;

    // A byte never both commits and aborts a frame.
    a_commit_error_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser))
        else $error("result marks both commit and overrun");

    // Backpressure on the input only with a byte waiting and the result stalled.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");

    // A byte moved out of the input register always shows up as a result.
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_tvalid)
        else $error("processed byte produced no result");

endmodule
